>>> hdl/pcm_pkg.sv
// Shared widths, fixed-point constants and the rotator angle table.
`default_nettype none

package pcm_pkg;

  // Datapath widths
  localparam int unsigned MAG_W  = 24;  // input magnitude, Q12.12
  localparam int unsigned ANG_W  = 24;  // input angle, Q3.20
  localparam int unsigned PROD_W = 48;  // magnitude product, Q24.24
  localparam int unsigned ZU_W   = 36;  // unsigned angle during range reduction, Q.30
  localparam int unsigned ZW     = 34;  // signed rotator residual angle, Q.30
  localparam int unsigned XW     = 58;  // signed rotator vector component, Q24.30 plus gain
  localparam int unsigned OUT_W  = 48;  // result part, Q27.20

  // Angle constants in Q.30
  localparam logic [ZU_W-1:0] HALF_PI        = 36'd1686629713;
  localparam logic [ZU_W-1:0] PI             = 36'd3373259426;
  localparam logic [ZU_W-1:0] TWO_PI         = 36'd6746518852;
  localparam logic [ZU_W-1:0] TWO_PI_X2      = 36'd13493037704;
  localparam logic [ZU_W-1:0] TWO_PI_X3      = 36'd20239556556;
  localparam logic [ZU_W-1:0] TWO_PI_X4      = 36'd26986075408;
  localparam logic [ZU_W-1:0] TWO_PI_LESS_HP = 36'd5059889139;

  // Inverse rotator gain in Q0.32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // Negative results above -0.005 (Q.20) snap to zero
  localparam logic [OUT_W-1:0]        SNAP_MAG = 48'd5243;
  localparam logic signed [OUT_W-1:0] SNAP_NEG = -48'sd5243;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // atan(2^-i) in Q.30, rounded to nearest
  function automatic logic [ZW-1:0] atan_q30(input int unsigned i);
    logic [ZW-1:0] r;
    begin
      r = '0;
      case (i)
        0: r = 34'd843314857;
        1: r = 34'd497837829;
        2: r = 34'd263043837;
        3: r = 34'd133525159;
        4: r = 34'd67021687;
        5: r = 34'd33543516;
        6: r = 34'd16775851;
        7: r = 34'd8388437;
        8: r = 34'd4194283;
        9: r = 34'd2097149;
        default: begin
          if (i <= 30) begin
            r = ZW'(64'd1 << (30 - i));
          end else begin
            r = '0;
          end
        end
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/pcm_range_reduce.sv
// Magnitude product, angle sum modulo two pi and quadrant pre-rotation.
`default_nettype none

module pcm_range_reduce (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic        [pcm_pkg::MAG_W-1:0]  mag_a_i,
  input  wire logic signed [pcm_pkg::ANG_W-1:0]  ang_a_i,
  input  wire logic        [pcm_pkg::MAG_W-1:0]  mag_b_i,
  input  wire logic signed [pcm_pkg::ANG_W-1:0]  ang_b_i,
  output logic                                   valid_o,
  output pcm_pkg::vec_t                          vec_o
);

  logic [3:0] vld_q;
  logic       vld5_q;

  logic [pcm_pkg::PROD_W-1:0] prod1_d, prod1_q, prod2_q, prod3_q, prod4_q;
  logic [pcm_pkg::ANG_W:0]    sum;
  logic [pcm_pkg::ZU_W-1:0]   z1_d, z1_q, z2_d, z2_q, z3_d, z3_q, z4_d, z4_q;

  logic signed [pcm_pkg::XW-1:0] mag_pos, mag_neg;
  logic [pcm_pkg::ZU_W-1:0]      z_diff;
  pcm_pkg::vec_t                 vec_d, vec_q;

  // Stage 1: exact product, angle sum in Q.30 offset by three turns to stay positive
  assign prod1_d = {24'd0, mag_a_i} * {24'd0, mag_b_i};
  assign sum     = {ang_a_i[pcm_pkg::ANG_W-1], ang_a_i} + {ang_b_i[pcm_pkg::ANG_W-1], ang_b_i};
  assign z1_d    = {sum[pcm_pkg::ANG_W], sum, 10'd0} + pcm_pkg::TWO_PI_X3;

  // Stages 2 to 4: drop four, two, one turn where they fit
  assign z2_d = (z1_q >= pcm_pkg::TWO_PI_X4) ? z1_q - pcm_pkg::TWO_PI_X4 : z1_q;
  assign z3_d = (z2_q >= pcm_pkg::TWO_PI_X2) ? z2_q - pcm_pkg::TWO_PI_X2 : z2_q;
  assign z4_d = (z3_q >= pcm_pkg::TWO_PI)    ? z3_q - pcm_pkg::TWO_PI    : z3_q;

  // Stage 5: fold into (-pi, pi] and pre-rotate by a quarter turn where needed
  assign mag_pos = $signed({4'd0, prod4_q, 6'd0});
  assign mag_neg = -mag_pos;

  always_comb begin
    vec_d = '0;
    if (z4_q <= pcm_pkg::HALF_PI) begin
      z_diff  = z4_q;
      vec_d.x = mag_pos;
    end else if (z4_q <= pcm_pkg::PI) begin
      z_diff  = z4_q - pcm_pkg::HALF_PI;
      vec_d.y = mag_pos;
    end else if (z4_q < pcm_pkg::TWO_PI_LESS_HP) begin
      z_diff  = z4_q - pcm_pkg::TWO_PI_LESS_HP;
      vec_d.y = mag_neg;
    end else begin
      z_diff  = z4_q - pcm_pkg::TWO_PI;
      vec_d.x = mag_pos;
    end
    vec_d.z = $signed(z_diff[pcm_pkg::ZW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vld5_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], valid_i};
      vld5_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    prod2_q <= prod1_q;
    prod3_q <= prod2_q;
    prod4_q <= prod3_q;
    z1_q    <= z1_d;
    z2_q    <= z2_d;
    z3_q    <= z3_d;
    z4_q    <= z4_d;
    vec_q   <= vec_d;
  end

  assign valid_o = vld5_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

>>> hdl/pcm_cordic_stage.sv
// One registered rotation step of the CORDIC rotator.
`default_nettype none

module pcm_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire pcm_pkg::vec_t vec_i,
  output logic          valid_o,
  output pcm_pkg::vec_t vec_o
);

  localparam logic signed [pcm_pkg::ZW-1:0] ATAN = $signed(pcm_pkg::atan_q30(SHIFT));

  logic signed [pcm_pkg::XW-1:0] x_in, y_in, dx, dy;
  logic signed [pcm_pkg::ZW-1:0] z_in;
  logic                          valid_q;
  pcm_pkg::vec_t                 vec_d, vec_q;

  assign x_in = vec_i.x;
  assign y_in = vec_i.y;
  assign z_in = vec_i.z;
  assign dx   = y_in >>> SHIFT;
  assign dy   = x_in >>> SHIFT;

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_in[pcm_pkg::ZW-1]) begin
      vec_d.x = x_in - dx;
      vec_d.y = y_in + dy;
      vec_d.z = z_in - ATAN;
    end else begin
      vec_d.x = x_in + dx;
      vec_d.y = y_in - dy;
      vec_d.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

>>> hdl/pcm_gain_round.sv
// Gain removal, rounding to Q27.20 and near-zero snap for one vector component.
`default_nettype none

module pcm_gain_round (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [pcm_pkg::XW-1:0]      v_i,
  output logic                                    valid_o,
  output logic signed [pcm_pkg::OUT_W-1:0]        r_o
);

  logic [3:0] vld_q;

  logic [pcm_pkg::XW-1:0]    v_abs;
  logic [pcm_pkg::XW-2:0]    a1_q;
  logic                      neg1_q, neg2_q, neg3_q;
  logic [56:0]               phi_d, phi_q;
  logic [63:0]               plo_d, plo_q, lo_rnd;
  logic [57:0]               m_d, m_q, m_rnd;
  logic [pcm_pkg::OUT_W-1:0] q;
  logic signed [pcm_pkg::OUT_W-1:0] r_d, r_q;

  // Stage 1: sign and magnitude
  assign v_abs = v_i[pcm_pkg::XW-1] ? -v_i : v_i;

  // Stage 2: scale by the inverse gain in two partial products
  assign phi_d = {32'd0, a1_q[pcm_pkg::XW-2:32]} * {25'd0, pcm_pkg::INV_GAIN};
  assign plo_d = {32'd0, a1_q[31:0]} * {32'd0, pcm_pkg::INV_GAIN};

  // Stage 3: join the partial products, rounding the low one
  assign lo_rnd = plo_q + 64'h0000_0000_8000_0000;
  assign m_d    = {1'b0, phi_q} + {26'd0, lo_rnd[63:32]};

  // Stage 4: round to Q.20, restore sign, snap tiny negatives
  assign m_rnd = m_q + 58'd512;
  assign q     = m_rnd[57:10];

  always_comb begin
    if (!neg3_q) begin
      r_d = $signed(q);
    end else if (q < pcm_pkg::SNAP_MAG) begin
      r_d = '0;
    end else begin
      r_d = -$signed(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= v_abs[pcm_pkg::XW-2:0];
    neg1_q <= v_i[pcm_pkg::XW-1];
    phi_q  <= phi_d;
    plo_q  <= plo_d;
    neg2_q <= neg1_q;
    m_q    <= m_d;
    neg3_q <= neg2_q;
    r_q    <= r_d;
  end

  assign valid_o = vld_q[3];
  assign r_o     = r_q;

  a_snap_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && r_q[pcm_pkg::OUT_W-1]) |-> (r_q <= pcm_pkg::SNAP_NEG))
    else $error("negative result above snap limit");

endmodule

`default_nettype wire

>>> hdl/polar_complex_multiply_core.sv
// Top level: polar complex multiply through a pipelined CORDIC rotator.
`default_nettype none

// Pipeline from start to done_o: 5 range-reduction stages, one stage per rotator step,
//   4 gain and rounding stages.
// Throughput: one item per cycle; busy stays low, so every cycle with start high is an item.
// Results appear for one cycle with done_o; the receiver cannot stall the pipeline.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.

module polar_complex_multiply_core #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [pcm_pkg::MAG_W-1:0]  mag_a_i,
  input  wire logic signed [pcm_pkg::ANG_W-1:0]  ang_a_i,
  input  wire logic        [pcm_pkg::MAG_W-1:0]  mag_b_i,
  input  wire logic signed [pcm_pkg::ANG_W-1:0]  ang_b_i,
  output logic                                   done_o,
  output logic signed [pcm_pkg::OUT_W-1:0]       real_part_o,
  output logic signed [pcm_pkg::OUT_W-1:0]       imag_part_o
);

  localparam int unsigned LATENCY = CORDIC_ITERATIONS + 9;

  // Rotator chain: entry 0 comes from range reduction, entry N feeds gain removal
  pcm_pkg::vec_t cv    [CORDIC_ITERATIONS+1];
  logic          cv_vld[CORDIC_ITERATIONS+1];
  logic          imag_vld;

  // The pipeline never holds off an item
  assign busy = 1'b0;

  // Multiply magnitudes, reduce the angle sum, pre-rotate by a quarter turn where needed
  pcm_range_reduce u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .mag_a_i (mag_a_i),
    .ang_a_i (ang_a_i),
    .mag_b_i (mag_b_i),
    .ang_b_i (ang_b_i),
    .valid_o (cv_vld[0]),
    .vec_o   (cv[0])
  );

  // One rotation step per stage; step i shifts by i and uses atan(2^-i)
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_rot
    pcm_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv_vld[i]),
      .vec_i   (cv[i]),
      .valid_o (cv_vld[i+1]),
      .vec_o   (cv[i+1])
    );
  end

  // Remove rotator gain and round each component; both lanes share timing
  pcm_gain_round u_real (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv_vld[CORDIC_ITERATIONS]),
    .v_i     (cv[CORDIC_ITERATIONS].x),
    .valid_o (done_o),
    .r_o     (real_part_o)
  );

  pcm_gain_round u_imag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv_vld[CORDIC_ITERATIONS]),
    .v_i     (cv[CORDIC_ITERATIONS].y),
    .valid_o (imag_vld),
    .r_o     (imag_part_o)
  );

  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("item did not complete after pipeline latency");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_lane_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == imag_vld)
    else $error("real and imaginary lanes out of step");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the polar complex multiply core.
module testbench;

  localparam int unsigned ROT_STEPS = 24;
  localparam int unsigned LATENCY   = ROT_STEPS + 9;
  localparam int unsigned N_DIRECTED = 23;
  localparam int unsigned N_RANDOM   = 1050;

  // Angle constants: Q.30 for the rotator, Q3.20 for building stimulus
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam int     Q20_HALF_PI = 1647099;
  localparam int     Q20_PI      = 3294199;
  localparam int     Q20_TWO_PI  = 6588397;

  // 1/K in Q0.32 and the near-zero negative limit in Q.20
  localparam longint unsigned GAIN_COMP = 64'd2608131496;
  localparam longint          SNAP_BAND = -64'sd5243;

  // atan(2^-i) in Q.30 for the steps where it differs from 2^-i
  localparam longint ARCTAN_Q30 [10] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
    64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149
  };

  typedef logic        [pcm_pkg::MAG_W-1:0] mag_t;
  typedef logic signed [pcm_pkg::ANG_W-1:0] ang_t;
  typedef logic signed [pcm_pkg::OUT_W-1:0] part_t;

  typedef struct packed {
    part_t real_part;
    part_t imag_part;
  } product_t;

  // One row of stimulus; typed rows carry a product read off by hand
  typedef struct packed {
    mag_t  mag_a;
    ang_t  ang_a;
    mag_t  mag_b;
    ang_t  ang_b;
    bit    typed;
    part_t real_part;
    part_t imag_part;
  } stim_row_t;

  // Directed rows: zero and extreme fields, quadrant and wrap boundaries,
  // and parts that land just inside and just outside the snap-to-zero band.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{24'd0,        24'sd0,        24'd0,        24'sd0,        1'b1, 48'sd0, 48'sd0},
    '{24'd0,        24'sd8388607,  24'd16777215, -24'sd8388608, 1'b1, 48'sd0, 48'sd0},
    '{24'd16777215, 24'sd0,        24'd0,        24'sd8388607,  1'b1, 48'sd0, 48'sd0},
    '{24'd1,        24'sd0,        24'd1,        24'sd0,        1'b1, 48'sd0, 48'sd0},
    '{24'd16777215, 24'sd0,        24'd16777215, 24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd16777215, 24'sd8388607,  24'd16777215, 24'sd8388607,  1'b0, 48'sd0, 48'sd0},
    '{24'd16777215, -24'sd8388608, 24'd16777215, -24'sd8388608, 1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd1647099,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd1647100,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     -24'sd1647099, 24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     -24'sd1647100, 24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd3294198,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd3294199,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     -24'sd3294199, 24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd6588397,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd3294199,  24'd4096,     24'sd3294199,  1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd1650245,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd1653391,  24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd0,        24'd20,       24'sd3294198,  1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd0,        24'd21,       24'sd3294198,  1'b0, 48'sd0, 48'sd0},
    '{24'd4096,     24'sd0,        24'd4096,     24'sd0,        1'b0, 48'sd0, 48'sd0},
    '{24'hAAAAAA,   24'hAAAAAA,    24'h555555,   24'h555555,    1'b0, 48'sd0, 48'sd0},
    '{24'h555555,   24'h555555,    24'hAAAAAA,   24'hAAAAAA,    1'b0, 48'sd0, 48'sd0}
  };

  logic  clk_i;
  logic  rst_ni  = 1'b0;
  logic  start   = 1'b0;
  logic  busy;
  mag_t  mag_a_i = '0;
  ang_t  ang_a_i = '0;
  mag_t  mag_b_i = '0;
  ang_t  ang_b_i = '0;
  logic  done_o;
  part_t real_part_o;
  part_t imag_part_o;

  product_t expected_products[$];
  int unsigned failures     = 0;
  int unsigned items_sent   = 0;
  int unsigned products_ok  = 0;
  int unsigned snapped_parts = 0;
  int unsigned calm_left    = 0;

  polar_complex_multiply_core #(
    .CORDIC_ITERATIONS(ROT_STEPS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .mag_a_i    (mag_a_i),
    .ang_a_i    (ang_a_i),
    .mag_b_i    (mag_b_i),
    .ang_b_i    (ang_b_i),
    .done_o     (done_o),
    .real_part_o(real_part_o),
    .imag_part_o(imag_part_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Strip the rotator gain, round Q24.30 to Q.20 half away from zero,
  // then flush a negative part that lies inside the snap band.
  function automatic part_t scale_part(input longint v);
    bit                neg;
    longint unsigned   mag, hi, lo, scaled, rounded;
    longint            r;
    neg     = (v < 0);
    mag     = neg ? longint'(-v) : v;
    hi      = mag >> 32;
    lo      = mag & 64'hFFFF_FFFF;
    scaled  = hi * GAIN_COMP + ((lo * GAIN_COMP + 64'h8000_0000) >> 32);
    rounded = (scaled + 64'd512) >> 10;
    r       = neg ? -longint'(rounded) : longint'(rounded);
    if (r < 0 && r > SNAP_BAND) begin
      r = 0;
      snapped_parts++;
    end
    return r[pcm_pkg::OUT_W-1:0];
  endfunction

  // Multiply magnitudes, add and wrap angles, and rotate (|a||b|, 0).
  function automatic product_t predict_product(input mag_t ma, input ang_t aa,
                                               input mag_t mb, input ang_t ab);
    longint   mag, x, y, z, dx, dy, step_ang;
    product_t p;
    mag = (longint'(ma) * longint'(mb)) <<< 6;
    z   = (longint'(aa) + longint'(ab)) * 1024;
    z   = z % Q30_TWO_PI;
    if (z < 0) z += Q30_TWO_PI;
    if (z > Q30_PI) z -= Q30_TWO_PI;
    // Pre-rotate by a quarter turn so the residual stays in CORDIC range
    if (z > Q30_HALF_PI) begin
      x = 0;
      y = mag;
      z -= Q30_HALF_PI;
    end else if (z < -Q30_HALF_PI) begin
      x = 0;
      y = -mag;
      z += Q30_HALF_PI;
    end else begin
      x = mag;
      y = 0;
    end
    for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (i < 10) step_ang = ARCTAN_Q30[i];
      else if (i <= 30) step_ang = 64'sd1 << (30 - i);
      else step_ang = 0;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= step_ang;
      end else begin
        x += dx;
        y -= dy;
        z += step_ang;
      end
    end
    p.real_part = scale_part(x);
    p.imag_part = scale_part(y);
    return p;
  endfunction

  // Draw one random item from a mix of item classes.
  function automatic stim_row_t draw_item();
    stim_row_t row;
    int        kind, target, half_a;
    int        bases [7];
    bases = '{0, Q20_HALF_PI, -Q20_HALF_PI, Q20_PI, -Q20_PI, Q20_TWO_PI, -Q20_TWO_PI};
    row.typed     = 1'b0;
    row.real_part = '0;
    row.imag_part = '0;
    row.mag_a     = mag_t'($urandom);
    row.ang_a     = ang_t'($urandom);
    row.mag_b     = mag_t'($urandom);
    row.ang_b     = ang_t'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        // tiny magnitudes: parts cluster around the snap band
        row.mag_a = mag_t'($urandom_range(0, 400));
        row.mag_b = mag_t'($urandom_range(0, 400));
      end
      6, 7: begin
        // angle sum near a quadrant or wrap boundary, split over both inputs
        target = bases[$urandom_range(0, 6)] + int'($urandom_range(0, 4000)) - 2000;
        half_a = int'($urandom_range(0, 2000000)) - 1000000;
        row.ang_a = ang_t'(half_a);
        row.ang_b = ang_t'(target - half_a);
      end
      8: begin
        row.mag_a = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        row.mag_b = ($urandom_range(0, 2) != 0) ? 24'hFFFFFF : mag_t'($urandom);
        row.ang_a = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
        row.ang_b = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
      end
      9: begin
        row.mag_a = 24'd1 << $urandom_range(0, 23);
        row.mag_b = 24'd1 << $urandom_range(0, 23);
      end
      default: begin
      end
    endcase
    return row;
  endfunction

  // Present one item, hold it until accepted, and queue its product.
  task automatic offer_item(input stim_row_t row);
    product_t want;
    mag_a_i <= row.mag_a;
    ang_a_i <= row.ang_a;
    mag_b_i <= row.mag_b;
    ang_b_i <= row.ang_b;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (row.typed) begin
      want.real_part = row.real_part;
      want.imag_part = row.imag_part;
    end else begin
      want = predict_product(row.mag_a, row.ang_a, row.mag_b, row.ang_b);
    end
    expected_products.push_back(want);
    items_sent++;
  endtask

  // Insert a sender gap after an item: mostly none or short, a few long,
  // with calm stretches of back-to-back items in between.
  task automatic idle_after_item();
    int unsigned gap, roll;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(20, 80);
      else if (roll < 45) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      // drop start and scramble the idle fields; the core must ignore them
      start   <= 1'b0;
      mag_a_i <= mag_t'($urandom);
      ang_a_i <= ang_t'($urandom);
      mag_b_i <= mag_t'($urandom);
      ang_b_i <= ang_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Compare every strobed product against the oldest outstanding item.
  always @(posedge clk_i) begin
    product_t oldest;
    if (rst_ni && done_o) begin
      if (expected_products.size() == 0) begin
        $error("product with no item outstanding: real_part %0d imag_part %0d",
               real_part_o, imag_part_o);
        failures++;
      end else begin
        oldest = expected_products.pop_front();
        if (real_part_o !== oldest.real_part) begin
          $error("real_part mismatch: expected %0d, actual %0d",
                 oldest.real_part, real_part_o);
          failures++;
        end
        if (imag_part_o !== oldest.imag_part) begin
          $error("imag_part mismatch: expected %0d, actual %0d",
                 oldest.imag_part, imag_part_o);
          failures++;
        end
        products_ok++;
      end
    end
  end

  initial begin
    int unsigned drain;
    // hold reset low at the start, then release it for good
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table first
    foreach (DIRECTED_ROWS[k]) begin
      offer_item(DIRECTED_ROWS[k]);
      idle_after_item();
    end

    // Random items with random sender gaps
    for (int n = 0; n < N_RANDOM; n++) begin
      offer_item(draw_item());
      idle_after_item();
    end
    start <= 1'b0;

    // Drain the pipeline, then watch a little longer for stray strobes
    drain = 0;
    while (expected_products.size() != 0 && drain < 10 * LATENCY) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_products.size() != 0) begin
      $error("%0d products never arrived", expected_products.size());
      failures++;
    end
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Drove %0d items (%0d from the directed table), compared %0d products.",
             items_sent, N_DIRECTED, products_ok);
    $display("%0d predicted parts were flushed to zero from the snap band; %0d failures.",
             snapped_parts, failures);
    if (failures == 0) begin
      $display("polar_complex_multiply_core test passed");
    end else begin
      $display("polar_complex_multiply_core test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Timeout with %0d products still outstanding.", expected_products.size());
    $display("polar_complex_multiply_core test failed");
    $finish;
  end

endmodule
